>>> design/wide_word_stack_bytecode_engine_assert.svh
// assertion macros shared by the engine modules
`ifndef WIDE_WORD_STACK_BYTECODE_ENGINE_ASSERT_SVH
`define WIDE_WORD_STACK_BYTECODE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define WWSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WWSE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define WWSE_ASSERT(lbl, prop, msg)
`define WWSE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> design/wwse_pkg.sv
// constants, codes and types of the wide word stack engine
package wwse_pkg;

    localparam int CODE_DEPTH    = 4096;
    localparam int PAYLOAD_DEPTH = 256;
    localparam int STACK_DEPTH   = 1024;
    localparam int WORD_BITS     = 256;

    localparam int CODE_AW  = $clog2(CODE_DEPTH);
    localparam int PAY_AW   = $clog2(PAYLOAD_DEPTH);
    localparam int STK_AW   = $clog2(STACK_DEPTH);
    localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);

    localparam int RES_BITS   = 256;
    localparam int CHUNK_BITS = 64;
    localparam int CLEN_W     = 13;
    localparam int PLEN_W     = 9;
    localparam int PC_W       = 14;
    localparam int PPTR_W     = 10;

    localparam logic [1:0] MODE_CODE    = 2'd0;
    localparam logic [1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [1:0] MODE_RUN     = 2'd2;

    localparam logic [1:0] CFG_CODE_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_PAYLOAD_LENGTH = 2'd1;
    localparam logic [1:0] CFG_STEP_LIMIT     = 2'd2;

    localparam logic [31:0] STEP_LIMIT_RESET = 32'd1000000;

    localparam logic [7:0] OP_PUSH1  = 8'd0;
    localparam logic [7:0] OP_PUSH4  = 8'd1;
    localparam logic [7:0] OP_POP    = 8'd2;
    localparam logic [7:0] OP_ADD    = 8'd3;
    localparam logic [7:0] OP_SUB    = 8'd4;
    localparam logic [7:0] OP_DUP1   = 8'd5;
    localparam logic [7:0] OP_DUP2   = 8'd6;
    localparam logic [7:0] OP_DUP3   = 8'd7;
    localparam logic [7:0] OP_DUP4   = 8'd8;
    localparam logic [7:0] OP_LT     = 8'd9;
    localparam logic [7:0] OP_EQ     = 8'd10;
    localparam logic [7:0] OP_JUMP   = 8'd11;
    localparam logic [7:0] OP_JUMPI  = 8'd12;
    localparam logic [7:0] OP_CDLOAD = 8'd13;
    localparam logic [7:0] OP_CDSIZE = 8'd14;
    localparam logic [7:0] OP_REVERT = 8'd15;
    localparam logic [7:0] OP_SEND   = 8'd16;
    localparam logic [7:0] OP_RET    = 8'd17;

    typedef enum logic [2:0] {
        ST_OK, ST_UNDER, ST_OVER, ST_REVERT, ST_NOTEMPTY, ST_BADJUMP, ST_BADPAY, ST_STEPS
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_DECODE, S_IMM, S_RDA, S_RDB, S_LOAD, S_DONE
    } state_t;

    typedef struct packed {
        logic [RES_BITS-1:0] value;
        status_t             status;
    } res_t;

endpackage

>>> design/wwse_ram.sv
// simple dual port ram, one write port and one registered read port
module wwse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> design/wwse_result.sv
// result buffer, sends a finished run as four chunks
`include "wide_word_stack_bytecode_engine_assert.svh"
module wwse_result
    import wwse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  res_t                  res,
    output logic                  busy,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [CHUNK_BITS-1:0] result_chunk,
    output logic [1:0]            chunk_index,
    output logic [2:0]            status,
    output logic                  last
);

    res_t       res_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       take;

    assign take = valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            if (idx_reg == 2'd3)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign busy         = valid_reg;
    assign result_valid = valid_reg;
    assign result_chunk = res_reg.value[32'(idx_reg) * CHUNK_BITS +: CHUNK_BITS];
    assign chunk_index  = idx_reg;
    assign status       = res_reg.status;
    assign last         = (idx_reg == 2'd3);

    `WWSE_ASSERT(a_load_free, !(load && valid_reg), "result loaded over a pending one")
    `WWSE_ASSERT_NEXT(a_last_ends, take && idx_reg == 2'd3 && !load, !valid_reg, "run kept after last chunk")
    `WWSE_ASSERT_NEXT(a_status_hold, valid_reg && !load, $stable(res_reg.status), "status changed inside a run")

endmodule

>>> design/wide_word_stack_bytecode_engine.sv
// Load words (mode code or payload) are taken one per cycle whenever the engine is idle.
// A run word starts the program from address 0 and holds off further words until the
// run ends; each instruction passes through a check state and a decode state after the
// code fetch, then reads its stack operands one after another from the stack memory (one
// read port), its immediate bytes from the code memory and, for calldataload, its payload
// bytes one by one; of the other instructions push4 takes the longest. The four result
// chunks then leave one per cycle from an output buffer, unless result_stall holds them,
// while the next word is already accepted. Code, payload and stack live in synchronous
// memories; none of them is cleared at reset.
`include "wide_word_stack_bytecode_engine_assert.svh"
module wide_word_stack_bytecode_engine
    import wwse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            mode,
    input  logic [11:0]           address,
    input  logic [7:0]            byte_value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [CHUNK_BITS-1:0] result_chunk,
    output logic [1:0]            chunk_index,
    output logic [2:0]            status,
    output logic                  last
);

    state_t                state_reg, state_next;
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [PC_W-1:0]       ptr_reg, ptr_next;
    logic [PPTR_W-1:0]     pptr_reg, pptr_next;
    logic [PPTR_W-1:0]     cnt_reg, cnt_next;
    logic [31:0]           steps_reg, steps_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [WORD_BITS-1:0]  retval_reg, retval_next;
    logic [WORD_BITS-1:0]  a_reg, a_next;
    logic [7:0]            op_reg, op_next;
    status_t               status_reg, status_next;

    logic [CLEN_W-1:0]     code_len_reg;
    logic [PLEN_W-1:0]     pay_len_reg;
    logic [31:0]           step_limit_reg;

    logic                  code_wen, pay_wen;
    logic [PC_W-1:0]       code_raddr;
    logic [7:0]            code_q, code_byte;
    logic                  code_ok_reg;
    logic [PPTR_W-1:0]     pay_raddr;
    logic [7:0]            pay_q, pay_byte;
    logic                  pay_ok_reg;
    logic                  stk_wen;
    logic [STK_AW-1:0]     stk_waddr, stk_raddr;
    logic [WORD_BITS-1:0]  stk_wdata, stk_q;

    logic                  res_load, res_busy;
    res_t                  res_in;

    function automatic logic target_bad(input logic [WORD_BITS-1:0] t,
                                        input logic [CLEN_W-1:0] lim);
        return (|t[WORD_BITS-1:CLEN_W]) || (t[CLEN_W-1:0] > lim);
    endfunction

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_len_reg   <= '0;
            pay_len_reg    <= '0;
            step_limit_reg <= STEP_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CODE_LENGTH:    code_len_reg   <= cfg_data[CLEN_W-1:0];
                CFG_PAYLOAD_LENGTH: pay_len_reg    <= cfg_data[PLEN_W-1:0];
                CFG_STEP_LIMIT:     step_limit_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // stores
    assign code_wen = (state_reg == S_IDLE) && item_valid && (mode == MODE_CODE)
                      && (32'(address) < CODE_DEPTH);
    assign pay_wen  = (state_reg == S_IDLE) && item_valid && (mode == MODE_PAYLOAD)
                      && (32'(address) < PAYLOAD_DEPTH);

    wwse_ram #(.WIDTH(8), .DEPTH(CODE_DEPTH)) u_code (
        .clk   (clk),
        .wen   (code_wen),
        .waddr (CODE_AW'(address)),
        .wdata (byte_value),
        .raddr (CODE_AW'(code_raddr)),
        .rdata (code_q)
    );

    wwse_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_payload (
        .clk   (clk),
        .wen   (pay_wen),
        .waddr (PAY_AW'(address)),
        .wdata (byte_value),
        .raddr (PAY_AW'(pay_raddr)),
        .rdata (pay_q)
    );

    wwse_ram #(.WIDTH(WORD_BITS), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .wen   (stk_wen),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    // bytes past the valid range read as zero
    always_ff @(posedge clk)
    begin
        code_ok_reg <= (code_raddr < PC_W'(code_len_reg)) && (32'(code_raddr) < CODE_DEPTH);
        pay_ok_reg  <= (32'(pay_raddr) < PAYLOAD_DEPTH);
    end

    assign code_byte = code_ok_reg ? code_q : 8'd0;
    assign pay_byte  = pay_ok_reg ? pay_q : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            steps_reg  <= '0;
            depth_reg  <= '0;
            retval_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            steps_reg  <= steps_next;
            depth_reg  <= depth_next;
            retval_reg <= retval_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        pptr_reg <= pptr_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        op_reg   <= op_next;
    end

    always_comb
    begin
        logic                 push_req;
        logic [WORD_BITS-1:0] push_val;
        logic [PC_W-1:0]      push_pc;
        logic [DEPTH_W-1:0]   dup_n;
        logic                 sz_ok, off_ok;
        logic [PPTR_W-1:0]    pay_sum;

        state_next  = state_reg;
        pc_next     = pc_reg;
        ptr_next    = ptr_reg;
        pptr_next   = pptr_reg;
        cnt_next    = cnt_reg;
        steps_next  = steps_reg;
        depth_next  = depth_reg;
        retval_next = retval_reg;
        a_next      = a_reg;
        op_next     = op_reg;
        status_next = status_reg;
        code_raddr  = pc_reg;
        pay_raddr   = pptr_reg;
        stk_raddr   = '0;
        stk_wen     = 1'b0;
        stk_waddr   = '0;
        stk_wdata   = '0;
        res_load    = 1'b0;
        item_stall  = (state_reg != S_IDLE);
        push_req    = 1'b0;
        push_val    = '0;
        push_pc     = pc_reg + PC_W'(1);
        dup_n       = DEPTH_W'(code_byte - OP_DUP1) + DEPTH_W'(1);
        sz_ok       = ~|a_reg[WORD_BITS-1:PLEN_W] && (a_reg[PLEN_W-1:0] <= pay_len_reg);
        off_ok      = ~|stk_q[WORD_BITS-1:PLEN_W] && (stk_q[PLEN_W-1:0] <= pay_len_reg);
        pay_sum     = PPTR_W'(a_reg[PLEN_W-1:0]) + PPTR_W'(stk_q[PLEN_W-1:0]);

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && mode == MODE_RUN)
                begin
                    pc_next     = '0;
                    steps_next  = '0;
                    depth_next  = '0;
                    retval_next = '0;
                    status_next = ST_OK;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (pc_reg >= PC_W'(code_len_reg))
                begin
                    status_next = (depth_reg != '0) ? ST_NOTEMPTY : ST_OK;
                    state_next  = S_DONE;
                end
                else if (steps_reg >= step_limit_reg)
                begin
                    status_next = ST_STEPS;
                    state_next  = S_DONE;
                end
                else
                begin
                    steps_next = steps_reg + 32'd1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                op_next = code_byte;
                case (code_byte)
                    OP_PUSH1, OP_PUSH4:
                    begin
                        code_raddr = pc_reg + PC_W'(1);
                        ptr_next   = pc_reg + PC_W'(2);
                        cnt_next   = (code_byte == OP_PUSH1) ? PPTR_W'(1) : PPTR_W'(4);
                        a_next     = '0;
                        state_next = S_IMM;
                    end
                    OP_POP:
                    begin
                        if (depth_reg < DEPTH_W'(1))
                        begin
                            status_next = ST_UNDER;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            depth_next = depth_reg - DEPTH_W'(1);
                            pc_next    = pc_reg + PC_W'(1);
                            state_next = S_CHECK;
                        end
                    end
                    OP_ADD, OP_SUB, OP_LT, OP_EQ, OP_JUMPI, OP_CDLOAD:
                    begin
                        stk_raddr = STK_AW'(depth_reg - DEPTH_W'(1));
                        if (depth_reg < DEPTH_W'(2))
                        begin
                            status_next = ST_UNDER;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RDA;
                        end
                    end
                    OP_JUMP, OP_RET:
                    begin
                        stk_raddr = STK_AW'(depth_reg - DEPTH_W'(1));
                        if (depth_reg < DEPTH_W'(1))
                        begin
                            status_next = ST_UNDER;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RDA;
                        end
                    end
                    OP_DUP1, OP_DUP2, OP_DUP3, OP_DUP4:
                    begin
                        stk_raddr = STK_AW'(depth_reg - dup_n);
                        if (depth_reg < dup_n)
                        begin
                            status_next = ST_UNDER;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RDA;
                        end
                    end
                    OP_CDSIZE:
                    begin
                        push_req = 1'b1;
                        push_val = WORD_BITS'(pay_len_reg);
                    end
                    OP_REVERT, OP_SEND:
                    begin
                        status_next = ST_REVERT;
                        state_next  = S_DONE;
                    end
                    default:
                    begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = S_CHECK;
                    end
                endcase
            end
            S_IMM:
            begin
                a_next     = {a_reg[WORD_BITS-9:0], code_byte};
                code_raddr = ptr_reg;
                ptr_next   = ptr_reg + PC_W'(1);
                cnt_next   = cnt_reg - PPTR_W'(1);
                if (cnt_reg == PPTR_W'(1))
                begin
                    push_req = 1'b1;
                    push_val = a_next;
                    push_pc  = pc_reg + ((op_reg == OP_PUSH1) ? PC_W'(2) : PC_W'(5));
                end
            end
            S_RDA:
            begin
                case (op_reg)
                    OP_DUP1, OP_DUP2, OP_DUP3, OP_DUP4:
                    begin
                        push_req = 1'b1;
                        push_val = stk_q;
                    end
                    OP_RET:
                    begin
                        retval_next = stk_q;
                        depth_next  = depth_reg - DEPTH_W'(1);
                        pc_next     = pc_reg + PC_W'(1);
                        state_next  = S_CHECK;
                    end
                    OP_JUMP:
                    begin
                        depth_next = depth_reg - DEPTH_W'(1);
                        if (target_bad(stk_q, code_len_reg))
                        begin
                            status_next = ST_BADJUMP;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pc_next    = PC_W'(stk_q[CLEN_W-1:0]);
                            state_next = S_CHECK;
                        end
                    end
                    default:
                    begin
                        a_next     = stk_q;
                        stk_raddr  = STK_AW'(depth_reg - DEPTH_W'(2));
                        state_next = S_RDB;
                    end
                endcase
            end
            S_RDB:
            begin
                // a_reg holds the top word, stk_q the one below it
                stk_waddr = STK_AW'(depth_reg - DEPTH_W'(2));
                case (op_reg)
                    OP_ADD, OP_SUB, OP_LT, OP_EQ:
                    begin
                        stk_wen = 1'b1;
                        case (op_reg)
                            OP_ADD:  stk_wdata = stk_q + a_reg;
                            OP_SUB:  stk_wdata = stk_q - a_reg;
                            OP_LT:   stk_wdata = WORD_BITS'(a_reg < stk_q);
                            default: stk_wdata = WORD_BITS'(a_reg == stk_q);
                        endcase
                        depth_next = depth_reg - DEPTH_W'(1);
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = S_CHECK;
                    end
                    OP_JUMPI:
                    begin
                        depth_next = depth_reg - DEPTH_W'(2);
                        if (stk_q == '0)
                        begin
                            pc_next    = pc_reg + PC_W'(1);
                            state_next = S_CHECK;
                        end
                        else if (target_bad(a_reg, code_len_reg))
                        begin
                            status_next = ST_BADJUMP;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            pc_next    = PC_W'(a_reg[CLEN_W-1:0]);
                            state_next = S_CHECK;
                        end
                    end
                    default:
                    begin
                        // calldataload: size on top, offset below
                        pay_raddr = PPTR_W'(stk_q[PLEN_W-1:0]);
                        pptr_next = PPTR_W'(stk_q[PLEN_W-1:0]) + PPTR_W'(1);
                        cnt_next  = PPTR_W'(a_reg[PLEN_W-1:0]);
                        a_next    = '0;
                        if (!sz_ok || !off_ok || pay_sum > PPTR_W'(pay_len_reg))
                        begin
                            status_next = ST_BADPAY;
                            state_next  = S_DONE;
                        end
                        else if (a_reg[PLEN_W-1:0] == '0)
                        begin
                            stk_wen    = 1'b1;
                            stk_wdata  = '0;
                            depth_next = depth_reg - DEPTH_W'(1);
                            pc_next    = pc_reg + PC_W'(1);
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            state_next = S_LOAD;
                        end
                    end
                endcase
            end
            S_LOAD:
            begin
                a_next    = {a_reg[WORD_BITS-9:0], pay_byte};
                pay_raddr = pptr_reg;
                pptr_next = pptr_reg + PPTR_W'(1);
                cnt_next  = cnt_reg - PPTR_W'(1);
                if (cnt_reg == PPTR_W'(1))
                begin
                    stk_wen    = 1'b1;
                    stk_waddr  = STK_AW'(depth_reg - DEPTH_W'(2));
                    stk_wdata  = a_next;
                    depth_next = depth_reg - DEPTH_W'(1);
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!res_busy)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_req)
        begin
            if (depth_reg >= DEPTH_W'(STACK_DEPTH))
            begin
                status_next = ST_OVER;
                state_next  = S_DONE;
            end
            else
            begin
                stk_wen    = 1'b1;
                stk_waddr  = STK_AW'(depth_reg);
                stk_wdata  = push_val;
                depth_next = depth_reg + DEPTH_W'(1);
                pc_next    = push_pc;
                state_next = S_CHECK;
            end
        end
    end

    assign res_in.value  = (status_reg == ST_OK) ? RES_BITS'(retval_reg) : '0;
    assign res_in.status = status_reg;

    wwse_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (res_load),
        .res          (res_in),
        .busy         (res_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_chunk (result_chunk),
        .chunk_index  (chunk_index),
        .status       (status),
        .last         (last)
    );

    `WWSE_ASSERT(a_depth_bound, depth_reg <= DEPTH_W'(STACK_DEPTH), "stack depth past capacity")
    `WWSE_ASSERT(a_write_top, !stk_wen || (32'(stk_waddr) <= 32'(depth_reg)), "stack write above top")
    `WWSE_ASSERT(a_steps_bound, state_reg != S_CHECK || steps_reg <= step_limit_reg, "step count past limit")
    `WWSE_ASSERT_NEXT(a_run_start, item_valid && !item_stall && mode == MODE_RUN, state_reg == S_CHECK && depth_reg == '0, "run did not start clean")

endmodule
